>>> rtl/yuva420_block_to_packed_rgba_top_defines.svh
// ----------------------------------------------------------------------------
// YUVA 4:2:0 block converter assertion macros
// Check macros shared by the converter RTL; they compile away under SYNTH.
// ----------------------------------------------------------------------------
`ifndef YUVA420_BLOCK_TO_PACKED_RGBA_TOP_DEFINES_SVH
`define YUVA420_BLOCK_TO_PACKED_RGBA_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define YRGB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("yrgb check failed: same-cycle implication");
// next-cycle implication
`define YRGB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("yrgb check failed: next-cycle implication");
`else
`define YRGB_ASSERT_IMP(lbl, ante, cons)
`define YRGB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/yrgb_pkg.sv
// ----------------------------------------------------------------------------
// YUVA 4:2:0 block converter package
// Register codes, shared types and the constant conversion tables.
// ----------------------------------------------------------------------------
package yrgb_pkg;

  localparam int unsigned NUM_PIX     = 4;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_SCALE_MODE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RED_SHIFT      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GREEN_SHIFT    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BLUE_SHIFT     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_SHIFT    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_LOSSES = 3'd5;

  // table selectors for the chroma term builder
  localparam int TERM_RED      = 0;
  localparam int TERM_GREEN_CR = 1;
  localparam int TERM_GREEN_CB = 2;
  localparam int TERM_BLUE     = 3;

  typedef logic signed [8:0] chroma_term_t;

  typedef struct packed {
    chroma_term_t red;
    chroma_term_t green;
    chroma_term_t blue;
  } chroma_off_t;

  typedef struct packed {
    logic        scale_mode;
    logic [4:0]  red_shift;
    logic [4:0]  green_shift;
    logic [4:0]  blue_shift;
    logic [4:0]  alpha_shift;
    logic [15:0] channel_losses;
  } pack_cfg_t;

  typedef logic [255:0][8:0] term_lut_t;
  typedef logic [255:0][7:0] level_lut_t;

  // Chroma term per 8-bit code, truncated toward zero like the exact quotient
  function automatic term_lut_t build_term_lut(input int sel);
    term_lut_t lut;
    int        v;
    int        t;
    for (int c = 0; c < 256; c++) begin
      v = c - 128;
      case (sel)
        TERM_RED:      t = (419 * v) / 299;
        TERM_GREEN_CR: t = (-299 * v) / 419;
        TERM_GREEN_CB: t = (-114 * v) / 331;
        default:       t = (587 * v) / 331;
      endcase
      lut[c] = 9'(t);
    end
    return lut;
  endfunction

  // Studio-range expansion: index is k-16 in 0..219
  function automatic level_lut_t build_level_lut();
    level_lut_t lut;
    for (int x = 0; x < 256; x++) begin
      if (x <= 219) begin
        lut[x] = 8'((x * 255) / 219);
      end else begin
        lut[x] = 8'd0;
      end
    end
    return lut;
  endfunction

  localparam term_lut_t  RED_TERM_LUT      = build_term_lut(TERM_RED);
  localparam term_lut_t  GREEN_CR_TERM_LUT = build_term_lut(TERM_GREEN_CR);
  localparam term_lut_t  GREEN_CB_TERM_LUT = build_term_lut(TERM_GREEN_CB);
  localparam term_lut_t  BLUE_TERM_LUT     = build_term_lut(TERM_BLUE);
  localparam level_lut_t STUDIO_LEVEL_LUT  = build_level_lut();

endpackage

>>> rtl/yrgb_chroma.sv
// ----------------------------------------------------------------------------
// Chroma offset lookup
// Turns the shared Cb/Cr pair into the red, green and blue luma offsets.
// ----------------------------------------------------------------------------
module yrgb_chroma (
  input  logic [7:0]                chroma_blue,
  input  logic [7:0]                chroma_red,
  output yrgb_pkg::chroma_off_t     offsets
);
  import yrgb_pkg::*;

  chroma_term_t      green_cr;
  chroma_term_t      green_cb;
  logic signed [9:0] green_sum;

  assign green_cr  = GREEN_CR_TERM_LUT[chroma_red];
  assign green_cb  = GREEN_CB_TERM_LUT[chroma_blue];
  // both terms are truncated on their own before the add
  assign green_sum = $signed({green_cr[8], green_cr}) + $signed({green_cb[8], green_cb});

  assign offsets.red   = RED_TERM_LUT[chroma_red];
  assign offsets.green = green_sum[8:0];
  assign offsets.blue  = BLUE_TERM_LUT[chroma_blue];

endmodule

>>> rtl/yrgb_pixel.sv
// ----------------------------------------------------------------------------
// Pixel channel build and pack
// Adds the chroma offsets to one luma sample, clamps or rescales each colour
// channel and packs the four channels into a 32-bit word.
// ----------------------------------------------------------------------------
module yrgb_pixel (
  input  logic [7:0]             luma,
  input  logic [7:0]             alpha,
  input  yrgb_pkg::chroma_off_t  offsets,
  input  yrgb_pkg::pack_cfg_t    cfg,
  output logic [31:0]            pixel
);
  import yrgb_pkg::*;

  logic [7:0] red_lvl;
  logic [7:0] green_lvl;
  logic [7:0] blue_lvl;

  function automatic logic [7:0] channel_level(input logic [7:0] y,
                                               input chroma_term_t off,
                                               input logic studio);
    logic signed [9:0] k;
    logic [9:0]        k_rel;
    logic [7:0]        idx;
    logic [7:0]        lvl;
    k     = $signed({2'b00, y}) + $signed({off[8], off});
    k_rel = k - 10'sd16;
    if (studio) begin
      if (k < 10'sd16) begin
        idx = 8'd0;
      end else if (k > 10'sd235) begin
        idx = 8'd219;
      end else begin
        idx = k_rel[7:0];
      end
      lvl = STUDIO_LEVEL_LUT[idx];
    end else begin
      if (k < 10'sd0) begin
        lvl = 8'd0;
      end else if (k > 10'sd255) begin
        lvl = 8'd255;
      end else begin
        lvl = k[7:0];
      end
    end
    return lvl;
  endfunction

  // drop loss bits, then move to the field position; bits past 31 fall off
  function automatic logic [31:0] place(input logic [7:0] v,
                                        input logic [3:0] loss,
                                        input logic [4:0] shift);
    return ({24'd0, v} >> loss) << shift;
  endfunction

  assign red_lvl   = channel_level(luma, offsets.red,   cfg.scale_mode);
  assign green_lvl = channel_level(luma, offsets.green, cfg.scale_mode);
  assign blue_lvl  = channel_level(luma, offsets.blue,  cfg.scale_mode);

  assign pixel = place(red_lvl,   cfg.channel_losses[11:8],  cfg.red_shift)
               | place(green_lvl, cfg.channel_losses[7:4],   cfg.green_shift)
               | place(blue_lvl,  cfg.channel_losses[3:0],   cfg.blue_shift)
               | place(alpha,     cfg.channel_losses[15:12], cfg.alpha_shift);

endmodule

>>> rtl/yuva420_block_to_packed_rgba_top.sv
// ----------------------------------------------------------------------------
// YUVA 4:2:0 block to packed RGBA converter
// Converts one 2x2 block (four luma, four alpha, one Cb/Cr pair) into four
// packed 32-bit pixels with programmable field positions and bit losses.
// ----------------------------------------------------------------------------
// The block takes one 2x2 request every clock while in_stall is low. Each
// request is held in an input register, goes through one pass of table
// lookups, offset add, clamp/rescale and field shift, and lands in the
// result register as four packed pixels. A full result register that is
// stalled also holds a full input register, so back-pressure reaches
// in_stall in the same cycle; otherwise requests flow at one per clock.
// Program the configuration registers only while no request is in flight.
`include "yuva420_block_to_packed_rgba_top_defines.svh"

module yuva420_block_to_packed_rgba_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_wr_en,
  input  logic [yrgb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [yrgb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_luma_top_left,
  input  logic [7:0]                         in_luma_top_right,
  input  logic [7:0]                         in_luma_bottom_left,
  input  logic [7:0]                         in_luma_bottom_right,
  input  logic [7:0]                         in_alpha_top_left,
  input  logic [7:0]                         in_alpha_top_right,
  input  logic [7:0]                         in_alpha_bottom_left,
  input  logic [7:0]                         in_alpha_bottom_right,
  input  logic [7:0]                         in_chroma_blue,
  input  logic [7:0]                         in_chroma_red,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [31:0]                        out_pixel_top_left,
  output logic [31:0]                        out_pixel_top_right,
  output logic [31:0]                        out_pixel_bottom_left,
  output logic [31:0]                        out_pixel_bottom_right
);
  import yrgb_pkg::*;

  pack_cfg_t                 cfg_r;
  pack_cfg_t                 cfg_nxt;

  logic                      s1_valid_r;
  logic [NUM_PIX-1:0][7:0]   luma_r;
  logic [NUM_PIX-1:0][7:0]   alpha_r;
  logic [7:0]                cb_r;
  logic [7:0]                cr_r;

  logic                      out_valid_r;
  logic [NUM_PIX-1:0][31:0]  pixel_r;
  logic [NUM_PIX-1:0][31:0]  pixel_nxt;

  chroma_off_t               offsets;
  logic                      out_advance;
  logic                      in_accept;

  // configuration decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SCALE_MODE:     cfg_nxt.scale_mode     = cfg_wdata[0];
        REG_RED_SHIFT:      cfg_nxt.red_shift      = cfg_wdata[4:0];
        REG_GREEN_SHIFT:    cfg_nxt.green_shift    = cfg_wdata[4:0];
        REG_BLUE_SHIFT:     cfg_nxt.blue_shift     = cfg_wdata[4:0];
        REG_ALPHA_SHIFT:    cfg_nxt.alpha_shift    = cfg_wdata[4:0];
        REG_CHANNEL_LOSSES: cfg_nxt.channel_losses = cfg_wdata[15:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale_mode     <= 1'b0;
      cfg_r.red_shift      <= 5'd16;
      cfg_r.green_shift    <= 5'd8;
      cfg_r.blue_shift     <= 5'd0;
      cfg_r.alpha_shift    <= 5'd24;
      cfg_r.channel_losses <= 16'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // advance the result register when empty or being taken
  assign out_advance = !out_valid_r || !out_stall;
  assign in_stall    = s1_valid_r && !out_advance;
  assign in_accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (out_advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      luma_r  <= {in_luma_bottom_right, in_luma_bottom_left,
                  in_luma_top_right, in_luma_top_left};
      alpha_r <= {in_alpha_bottom_right, in_alpha_bottom_left,
                  in_alpha_top_right, in_alpha_top_left};
      cb_r    <= in_chroma_blue;
      cr_r    <= in_chroma_red;
    end
    if (out_advance && s1_valid_r) begin
      pixel_r <= pixel_nxt;
    end
  end

  yrgb_chroma u_chroma (
    .chroma_blue (cb_r),
    .chroma_red  (cr_r),
    .offsets     (offsets)
  );

  for (genvar p = 0; p < NUM_PIX; p++) begin : g_pix
    yrgb_pixel u_pixel (
      .luma    (luma_r[p]),
      .alpha   (alpha_r[p]),
      .offsets (offsets),
      .cfg     (cfg_r),
      .pixel   (pixel_nxt[p])
    );
  end

  assign out_valid              = out_valid_r;
  assign out_pixel_top_left     = pixel_r[0];
  assign out_pixel_top_right    = pixel_r[1];
  assign out_pixel_bottom_left  = pixel_r[2];
  assign out_pixel_bottom_right = pixel_r[3];

  // back-pressure only when both stages are full and the result is held
  `YRGB_ASSERT_IMP(a_stall_needs_full_pipe, in_stall, s1_valid_r && out_valid_r && out_stall)
  // an accepted request always occupies the input register next cycle
  `YRGB_ASSERT_NEXT(a_accept_fills_s1, in_accept, s1_valid_r)
  // a request moving out of the input register always shows up as a result
  `YRGB_ASSERT_NEXT(a_s1_moves_to_out, s1_valid_r && out_advance, out_valid_r)
  // a held result is never dropped
  `YRGB_ASSERT_NEXT(a_held_result_kept, out_valid_r && out_stall, out_valid_r)

endmodule
